// File: hdl/pnm_header_parser_core_defines.svh
// Assertion macros shared by the parser RTL.
// Each macro samples on clock and is disabled while reset is high.
`ifndef PNM_HEADER_PARSER_CORE_DEFINES_SVH
`define PNM_HEADER_PARSER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNMHP_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNMHP_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/pnmhp_pkg.sv
package pnmhp_pkg;

   localparam int VALUE_BITS = 16;
   localparam int FIELD_BITS = 16;
   localparam int PHASE_BITS = 4;

   typedef logic [VALUE_BITS-1:0] acc_type;
   typedef logic [PHASE_BITS-1:0] phase_type;
   typedef logic [1:0] status_type;

   localparam acc_type VALUE_MAX = '1;

   localparam logic [7:0] CHAR_P       = 8'h50;
   localparam logic [7:0] CHAR_5       = 8'h35;
   localparam logic [7:0] CHAR_6       = 8'h36;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_1       = 8'h31;
   localparam logic [7:0] CHAR_9       = 8'h39;

   localparam phase_type PH_MAGIC_P = 4'd0;
   localparam phase_type PH_MAGIC_T = 4'd1;
   localparam phase_type PH_WS_W    = 4'd2;
   localparam phase_type PH_CM_W    = 4'd3;
   localparam phase_type PH_W       = 4'd4;
   localparam phase_type PH_WS_H    = 4'd5;
   localparam phase_type PH_CM_H    = 4'd6;
   localparam phase_type PH_H       = 4'd7;
   localparam phase_type PH_WS_M    = 4'd8;
   localparam phase_type PH_CM_M    = 4'd9;
   localparam phase_type PH_M       = 4'd10;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_NOT_P   = 2'd1;
   localparam status_type ST_NOT_RAW = 2'd2;
   localparam status_type ST_TRUNC   = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] width;
      logic [FIELD_BITS-1:0] height;
      logic [FIELD_BITS-1:0] max_value;
      logic                  is_colour;
      status_type            status;
      logic                  overflow;
   } rsp_type;

   typedef struct packed {
      phase_type phase;
      acc_type   width_acc;
      acc_type   height_acc;
      acc_type   maxval_acc;
      logic      colour_flag;
      logic      saturated;
   } ctx_type;

   localparam ctx_type CTX_RESET = '{PH_MAGIC_P, '0, '0, '0, 1'b0, 1'b0};

   typedef struct packed {
      acc_type value;
      logic    sat;
   } sum_type;

   // Multiply by ten as two shifts and add the digit, saturating at the top.
   function automatic sum_type add_digit(acc_type acc, logic [3:0] d);
      logic [VALUE_BITS+3:0] wide;
      logic [VALUE_BITS+3:0] ext;
      sum_type r;
      ext = {4'b0000, acc};
      wide = (ext << 3) + (ext << 1) + {{VALUE_BITS{1'b0}}, d};
      if (wide > {4'b0000, VALUE_MAX}) begin
         r.value = VALUE_MAX;
         r.sat = 1'b1;
      end else begin
         r.value = wide[VALUE_BITS-1:0];
         r.sat = 1'b0;
      end
      return r;
   endfunction

endpackage

// File: hdl/pnmhp_step.sv
module pnmhp_step (
   input  pnmhp_pkg::ctx_type cur_ctx,
   input  pnmhp_pkg::req_type req,
   output pnmhp_pkg::ctx_type nxt_ctx,
   output logic               emit,
   output pnmhp_pkg::rsp_type rsp
);

   logic [7:0] c;
   logic [3:0] digit;
   logic is_digit;
   logic starts_number;
   pnmhp_pkg::acc_type base;
   pnmhp_pkg::sum_type sum;

   assign c = req.data_byte;
   assign digit = c[3:0];
   assign is_digit = (c >= pnmhp_pkg::CHAR_0) && (c <= pnmhp_pkg::CHAR_9);
   assign starts_number = (c >= pnmhp_pkg::CHAR_1) && (c <= pnmhp_pkg::CHAR_9);

   // A single digit adder serves whichever number the phase is working on.
   always_comb begin
      case (cur_ctx.phase)
         pnmhp_pkg::PH_W: begin
            base = cur_ctx.width_acc;
         end
         pnmhp_pkg::PH_H: begin
            base = cur_ctx.height_acc;
         end
         pnmhp_pkg::PH_M: begin
            base = cur_ctx.maxval_acc;
         end
         default: begin
            base = '0;
         end
      endcase
   end

   assign sum = pnmhp_pkg::add_digit(base, digit);

   always_comb begin
      nxt_ctx = cur_ctx;
      emit = 1'b0;
      rsp.width = pnmhp_pkg::FIELD_BITS'(cur_ctx.width_acc);
      rsp.height = pnmhp_pkg::FIELD_BITS'(cur_ctx.height_acc);
      rsp.max_value = pnmhp_pkg::FIELD_BITS'(cur_ctx.maxval_acc);
      rsp.is_colour = cur_ctx.colour_flag;
      rsp.status = pnmhp_pkg::ST_OK;
      rsp.overflow = cur_ctx.saturated;
      if (req.end_of_input) begin
         emit = 1'b1;
         rsp.status = pnmhp_pkg::ST_TRUNC;
         nxt_ctx = pnmhp_pkg::CTX_RESET;
      end else begin
         case (cur_ctx.phase)
            pnmhp_pkg::PH_MAGIC_P: begin
               if (c != pnmhp_pkg::CHAR_P) begin
                  emit = 1'b1;
                  rsp = '0;
                  rsp.status = pnmhp_pkg::ST_NOT_P;
                  nxt_ctx = pnmhp_pkg::CTX_RESET;
               end else begin
                  nxt_ctx.phase = pnmhp_pkg::PH_MAGIC_T;
               end
            end
            pnmhp_pkg::PH_MAGIC_T: begin
               if ((c != pnmhp_pkg::CHAR_5) && (c != pnmhp_pkg::CHAR_6)) begin
                  emit = 1'b1;
                  rsp = '0;
                  rsp.status = pnmhp_pkg::ST_NOT_RAW;
                  nxt_ctx = pnmhp_pkg::CTX_RESET;
               end else begin
                  nxt_ctx.colour_flag = (c == pnmhp_pkg::CHAR_6);
                  nxt_ctx.phase = pnmhp_pkg::PH_WS_W;
               end
            end
            pnmhp_pkg::PH_WS_W: begin
               if (starts_number) begin
                  nxt_ctx.width_acc = sum.value;
                  nxt_ctx.saturated = cur_ctx.saturated | sum.sat;
                  nxt_ctx.phase = pnmhp_pkg::PH_W;
               end else if (c == pnmhp_pkg::CHAR_HASH) begin
                  nxt_ctx.phase = pnmhp_pkg::PH_CM_W;
               end
            end
            pnmhp_pkg::PH_CM_W: begin
               if (c == pnmhp_pkg::CHAR_NEWLINE) begin
                  nxt_ctx.phase = pnmhp_pkg::PH_WS_W;
               end
            end
            pnmhp_pkg::PH_W: begin
               if (is_digit) begin
                  nxt_ctx.width_acc = sum.value;
                  nxt_ctx.saturated = cur_ctx.saturated | sum.sat;
               end else if (c == pnmhp_pkg::CHAR_HASH) begin
                  nxt_ctx.phase = pnmhp_pkg::PH_CM_H;
               end else begin
                  nxt_ctx.phase = pnmhp_pkg::PH_WS_H;
               end
            end
            pnmhp_pkg::PH_WS_H: begin
               if (starts_number) begin
                  nxt_ctx.height_acc = sum.value;
                  nxt_ctx.saturated = cur_ctx.saturated | sum.sat;
                  nxt_ctx.phase = pnmhp_pkg::PH_H;
               end else if (c == pnmhp_pkg::CHAR_HASH) begin
                  nxt_ctx.phase = pnmhp_pkg::PH_CM_H;
               end
            end
            pnmhp_pkg::PH_CM_H: begin
               if (c == pnmhp_pkg::CHAR_NEWLINE) begin
                  nxt_ctx.phase = pnmhp_pkg::PH_WS_H;
               end
            end
            pnmhp_pkg::PH_H: begin
               if (is_digit) begin
                  nxt_ctx.height_acc = sum.value;
                  nxt_ctx.saturated = cur_ctx.saturated | sum.sat;
               end else if (c == pnmhp_pkg::CHAR_HASH) begin
                  nxt_ctx.phase = pnmhp_pkg::PH_CM_M;
               end else begin
                  nxt_ctx.phase = pnmhp_pkg::PH_WS_M;
               end
            end
            pnmhp_pkg::PH_WS_M: begin
               if (starts_number) begin
                  nxt_ctx.maxval_acc = sum.value;
                  nxt_ctx.saturated = cur_ctx.saturated | sum.sat;
                  nxt_ctx.phase = pnmhp_pkg::PH_M;
               end else if (c == pnmhp_pkg::CHAR_HASH) begin
                  nxt_ctx.phase = pnmhp_pkg::PH_CM_M;
               end
            end
            pnmhp_pkg::PH_CM_M: begin
               if (c == pnmhp_pkg::CHAR_NEWLINE) begin
                  nxt_ctx.phase = pnmhp_pkg::PH_WS_M;
               end
            end
            pnmhp_pkg::PH_M: begin
               if (is_digit) begin
                  nxt_ctx.maxval_acc = sum.value;
                  nxt_ctx.saturated = cur_ctx.saturated | sum.sat;
               end else begin
                  emit = 1'b1;
                  rsp.status = pnmhp_pkg::ST_OK;
                  nxt_ctx = pnmhp_pkg::CTX_RESET;
               end
            end
            default: begin
               nxt_ctx = pnmhp_pkg::CTX_RESET;
            end
         endcase
      end
   end

endmodule

// File: hdl/pnm_header_parser_core.sv
// The digit multiply-add and phase update are combinational; an emitted result is registered.
// Throughput: one request per cycle unless the result register is full and stalled.
// The input register stalls only while the result register is full and stalled.
// Reset is synchronous and active high: it returns the parser to the expect-P phase,
// clears the accumulators and flags, and empties both registers. No clearing pass follows.
`include "pnm_header_parser_core_defines.svh"

module pnm_header_parser_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pnmhp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pnmhp_pkg::rsp_type rsp_data
);

   logic in_valid_ff;
   logic in_valid_in;
   pnmhp_pkg::req_type in_data_ff;
   pnmhp_pkg::ctx_type ctx_ff;
   pnmhp_pkg::ctx_type ctx_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   pnmhp_pkg::rsp_type rsp_data_ff;

   logic advance;
   logic step_emit;
   pnmhp_pkg::ctx_type step_ctx;
   pnmhp_pkg::rsp_type step_rsp;

   logic rsp_bad_magic;
   logic rsp_no_values;
   logic acc_at_max;

   pnmhp_step u_step (
      .cur_ctx (ctx_ff),
      .req     (in_data_ff),
      .nxt_ctx (step_ctx),
      .emit    (step_emit),
      .rsp     (step_rsp)
   );

   assign advance = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? 1'b1 : req_valid;
   assign ctx_in = advance ? step_ctx : ctx_ff;
   assign rsp_valid_in = (advance && step_emit) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctx_ff <= pnmhp_pkg::CTX_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ctx_ff <= ctx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance && step_emit) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign rsp_bad_magic = (rsp_data_ff.status == pnmhp_pkg::ST_NOT_P) ||
                          (rsp_data_ff.status == pnmhp_pkg::ST_NOT_RAW);
   assign rsp_no_values = (rsp_data_ff.width == '0) && (rsp_data_ff.height == '0) &&
                          (rsp_data_ff.max_value == '0) && !rsp_data_ff.is_colour &&
                          !rsp_data_ff.overflow;
   assign acc_at_max = (ctx_ff.width_acc == pnmhp_pkg::VALUE_MAX) ||
                       (ctx_ff.height_acc == pnmhp_pkg::VALUE_MAX) ||
                       (ctx_ff.maxval_acc == pnmhp_pkg::VALUE_MAX);

   `PNMHP_CHECK_NEXT(a_phase_restart, advance && step_emit, ctx_ff.phase == pnmhp_pkg::PH_MAGIC_P, "no restart")
   `PNMHP_CHECK_NOW(a_bad_magic_zero, rsp_valid_ff && rsp_bad_magic, rsp_no_values, "bad magic values")
   `PNMHP_CHECK_NOW(a_sat_sticks, ctx_ff.saturated, acc_at_max, "saturation without a saturated value")

endmodule

// File: sim/pnm_header_parser_core_tb.sv
`timescale 1ns / 100ps

module pnm_header_parser_core_tb;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   pnmhp_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   pnmhp_pkg::rsp_type rsp_data;

   pnm_header_parser_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   pnmhp_pkg::req_type   pending_bytes[$];
   pnmhp_pkg::req_type   header_bytes[$];
   pnmhp_pkg::rsp_type   expected_headers[$];
   pnmhp_pkg::rsp_type   predicted;
   pnmhp_pkg::rsp_type   want;
   int                   items_queued = 0;
   int                   bytes_accepted = 0;
   int                   results_seen = 0;
   int                   mismatch_count = 0;
   int                   status_count[4] = '{0, 0, 0, 0};
   int                   overflow_count = 0;
   int                   send_idle_pct = 32;
   int                   recv_stall_pct = 70;
   logic                 hold_sender = 1'b0;

   pnmhp_pkg::phase_type ps_phase;
   pnmhp_pkg::acc_type   ps_width;
   pnmhp_pkg::acc_type   ps_height;
   pnmhp_pkg::acc_type   ps_maxval;
   logic                 ps_colour;
   logic                 ps_sat;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("[pnm_header_parser_core] ERROR");
      $finish;
   end

   function automatic void clear_parser();
      ps_phase = pnmhp_pkg::PH_MAGIC_P;
      ps_width = '0;
      ps_height = '0;
      ps_maxval = '0;
      ps_colour = 1'b0;
      ps_sat = 1'b0;
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= pnmhp_pkg::CHAR_0 && c <= pnmhp_pkg::CHAR_9;
   endfunction

   function automatic bit is_lead_digit(logic [7:0] c);
      return c >= pnmhp_pkg::CHAR_1 && c <= pnmhp_pkg::CHAR_9;
   endfunction

   // Decimal accumulate that sticks at the top of the value range.
   function automatic pnmhp_pkg::acc_type push_digit(pnmhp_pkg::acc_type acc, logic [7:0] c);
      logic [31:0] v;
      v = 32'(acc) * 32'd10 + 32'(c) - 32'(pnmhp_pkg::CHAR_0);
      if (v > 32'(pnmhp_pkg::VALUE_MAX)) begin
         ps_sat = 1'b1;
         return pnmhp_pkg::VALUE_MAX;
      end
      return pnmhp_pkg::acc_type'(v);
   endfunction

   function automatic bit parse_byte(input pnmhp_pkg::req_type r,
                                     output pnmhp_pkg::rsp_type y);
      logic [7:0]            c;
      bit                    done;
      bit                    keep;
      pnmhp_pkg::status_type st;
      c = r.data_byte;
      done = 1'b0;
      keep = 1'b1;
      st = pnmhp_pkg::ST_OK;
      y = '0;
      if (r.end_of_input) begin
         done = 1'b1;
         st = pnmhp_pkg::ST_TRUNC;
      end else begin
         case (ps_phase)
            pnmhp_pkg::PH_MAGIC_P: begin
               if (c != pnmhp_pkg::CHAR_P) begin
                  done = 1'b1;
                  keep = 1'b0;
                  st = pnmhp_pkg::ST_NOT_P;
               end else ps_phase = pnmhp_pkg::PH_MAGIC_T;
            end
            pnmhp_pkg::PH_MAGIC_T: begin
               if (c != pnmhp_pkg::CHAR_5 && c != pnmhp_pkg::CHAR_6) begin
                  done = 1'b1;
                  keep = 1'b0;
                  st = pnmhp_pkg::ST_NOT_RAW;
               end else begin
                  ps_colour = (c == pnmhp_pkg::CHAR_6);
                  ps_phase = pnmhp_pkg::PH_WS_W;
               end
            end
            pnmhp_pkg::PH_WS_W: begin
               if (is_lead_digit(c)) begin
                  ps_width = push_digit('0, c);
                  ps_phase = pnmhp_pkg::PH_W;
               end else if (c == pnmhp_pkg::CHAR_HASH) ps_phase = pnmhp_pkg::PH_CM_W;
            end
            pnmhp_pkg::PH_CM_W: begin
               if (c == pnmhp_pkg::CHAR_NEWLINE) ps_phase = pnmhp_pkg::PH_WS_W;
            end
            pnmhp_pkg::PH_W: begin
               if (is_digit(c)) ps_width = push_digit(ps_width, c);
               else if (c == pnmhp_pkg::CHAR_HASH) ps_phase = pnmhp_pkg::PH_CM_H;
               else ps_phase = pnmhp_pkg::PH_WS_H;
            end
            pnmhp_pkg::PH_WS_H: begin
               if (is_lead_digit(c)) begin
                  ps_height = push_digit('0, c);
                  ps_phase = pnmhp_pkg::PH_H;
               end else if (c == pnmhp_pkg::CHAR_HASH) ps_phase = pnmhp_pkg::PH_CM_H;
            end
            pnmhp_pkg::PH_CM_H: begin
               if (c == pnmhp_pkg::CHAR_NEWLINE) ps_phase = pnmhp_pkg::PH_WS_H;
            end
            pnmhp_pkg::PH_H: begin
               if (is_digit(c)) ps_height = push_digit(ps_height, c);
               else if (c == pnmhp_pkg::CHAR_HASH) ps_phase = pnmhp_pkg::PH_CM_M;
               else ps_phase = pnmhp_pkg::PH_WS_M;
            end
            pnmhp_pkg::PH_WS_M: begin
               if (is_lead_digit(c)) begin
                  ps_maxval = push_digit('0, c);
                  ps_phase = pnmhp_pkg::PH_M;
               end else if (c == pnmhp_pkg::CHAR_HASH) ps_phase = pnmhp_pkg::PH_CM_M;
            end
            pnmhp_pkg::PH_CM_M: begin
               if (c == pnmhp_pkg::CHAR_NEWLINE) ps_phase = pnmhp_pkg::PH_WS_M;
            end
            pnmhp_pkg::PH_M: begin
               if (is_digit(c)) ps_maxval = push_digit(ps_maxval, c);
               else done = 1'b1;
            end
            default: clear_parser();
         endcase
      end
      if (done) begin
         if (keep) begin
            y.width = ps_width;
            y.height = ps_height;
            y.max_value = ps_maxval;
            y.is_colour = ps_colour;
            y.overflow = ps_sat;
         end
         y.status = st;
         clear_parser();
      end
      return done;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_parser();
      end else begin
         if (req_valid && !req_stall) begin
            bytes_accepted++;
            if (parse_byte(req_data, predicted)) expected_headers.push_back(predicted);
         end
         if (!(req_valid && req_stall)) begin
            if (pending_bytes.size() != 0 && !hold_sender &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   function automatic string show_rsp(pnmhp_pkg::rsp_type r);
      return $sformatf("w=%0d h=%0d max=%0d colour=%0b st=%0d ovf=%0b",
                       r.width, r.height, r.max_value, r.is_colour, r.status, r.overflow);
   endfunction

   task automatic report_mismatch(string what, pnmhp_pkg::rsp_type exp_r,
                                  pnmhp_pkg::rsp_type got_r);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected %s, got %s", $time, what, show_rsp(exp_r),
                  show_rsp(got_r));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_headers.size() == 0) begin
            report_mismatch("result with nothing pending", '0, rsp_data);
         end else begin
            want = expected_headers.pop_front();
            if (rsp_data.width !== want.width || rsp_data.height !== want.height ||
                rsp_data.max_value !== want.max_value ||
                rsp_data.is_colour !== want.is_colour ||
                rsp_data.status !== want.status || rsp_data.overflow !== want.overflow) begin
               report_mismatch("header mismatch", want, rsp_data);
            end else begin
               status_count[want.status]++;
               if (want.overflow) overflow_count++;
            end
         end
      end
   end

   task automatic queue_item(logic [7:0] b, logic eoi);
      pnmhp_pkg::req_type r;
      r.data_byte = b;
      r.end_of_input = eoi;
      pending_bytes.push_back(r);
      items_queued++;
   endtask

   task automatic add_byte(logic [7:0] b);
      pnmhp_pkg::req_type r;
      r.data_byte = b;
      r.end_of_input = 1'b0;
      header_bytes.push_back(r);
   endtask

   function automatic logic [7:0] any_non_digit();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (is_digit(b));
      return b;
   endfunction

   function automatic logic [7:0] blank_byte();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0, 1: return CHAR_SPACE;
         2: return pnmhp_pkg::CHAR_NEWLINE;
         3: return CHAR_TAB;
         4: return CHAR_CR;
         default: begin
            do b = 8'($urandom_range(0, 255));
            while (is_lead_digit(b) || b == pnmhp_pkg::CHAR_HASH);
            return b;
         end
      endcase
   endfunction

   task automatic add_comment_body();
      int         n;
      logic [7:0] b;
      n = $urandom_range(0, 4);
      repeat (n) begin
         do b = 8'($urandom_range(0, 255)); while (b == pnmhp_pkg::CHAR_NEWLINE);
         add_byte(b);
      end
      add_byte(pnmhp_pkg::CHAR_NEWLINE);
   endtask

   // Separator before a number: an optional terminator of the previous number,
   // then a run of blanks and whole comments.
   task automatic add_gap(bit need_end);
      logic [7:0] b;
      int         n;
      if (need_end) begin
         b = ($urandom_range(0, 3) == 0) ? pnmhp_pkg::CHAR_HASH : any_non_digit();
         add_byte(b);
         if (b == pnmhp_pkg::CHAR_HASH) add_comment_body();
      end
      n = $urandom_range(0, 3);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0) begin
            add_byte(pnmhp_pkg::CHAR_HASH);
            add_comment_body();
         end else add_byte(blank_byte());
      end
   endtask

   task automatic add_number();
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
      add_byte(8'($urandom_range(pnmhp_pkg::CHAR_1, pnmhp_pkg::CHAR_9)));
      repeat (len - 1) add_byte(8'($urandom_range(pnmhp_pkg::CHAR_0, pnmhp_pkg::CHAR_9)));
   endtask

   task automatic queue_header();
      int         cut;
      logic [7:0] b;
      header_bytes.delete();
      if ($urandom_range(0, 19) == 0) begin
         do b = 8'($urandom_range(0, 255)); while (b == pnmhp_pkg::CHAR_P);
         add_byte(b);
      end else add_byte(pnmhp_pkg::CHAR_P);
      if ($urandom_range(0, 9) == 0) add_byte(8'($urandom_range(0, 255)));
      else add_byte($urandom_range(0, 1) ? pnmhp_pkg::CHAR_6 : pnmhp_pkg::CHAR_5);
      add_gap(1'b0);
      add_number();
      add_gap(1'b1);
      add_number();
      add_gap(1'b1);
      add_number();
      add_byte(any_non_digit());
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, header_bytes.size() - 1)
                                        : header_bytes.size();
      for (int i = 0; i < cut; i++) queue_item(header_bytes[i].data_byte, 1'b0);
      if (cut < header_bytes.size()) queue_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic queue_random(int n);
      int first;
      first = items_queued;
      while (items_queued - first < n) begin
         if ($urandom_range(0, 99) < 85) queue_header();
         else repeat ($urandom_range(1, 4))
            queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      @(negedge reset);

      queue_item(8'hFF, 1'b1);
      queue_item(8'h00, 1'b0);
      queue_item(pnmhp_pkg::CHAR_P, 1'b0);
      queue_item(8'hFF, 1'b0);
      // Colour header with comments, a saturated width ended by a hash, and
      // the input running out inside the maxval digits.
      queue_item(pnmhp_pkg::CHAR_P, 1'b0);
      queue_item(pnmhp_pkg::CHAR_6, 1'b0);
      queue_item(pnmhp_pkg::CHAR_HASH, 1'b0);
      queue_item(pnmhp_pkg::CHAR_NEWLINE, 1'b0);
      queue_item(8'h37, 1'b0);
      repeat (4) queue_item(pnmhp_pkg::CHAR_0, 1'b0);
      queue_item(pnmhp_pkg::CHAR_HASH, 1'b0);
      queue_item(pnmhp_pkg::CHAR_NEWLINE, 1'b0);
      queue_item(pnmhp_pkg::CHAR_1, 1'b0);
      queue_item(CHAR_SPACE, 1'b0);
      queue_item(pnmhp_pkg::CHAR_9, 1'b0);
      queue_item(8'h00, 1'b1);
      queue_item(pnmhp_pkg::CHAR_P, 1'b0);
      queue_item(pnmhp_pkg::CHAR_5, 1'b0);
      queue_item(pnmhp_pkg::CHAR_1, 1'b0);
      queue_item(CHAR_SPACE, 1'b0);
      queue_item(pnmhp_pkg::CHAR_1, 1'b0);
      queue_item(CHAR_SPACE, 1'b0);
      queue_item(pnmhp_pkg::CHAR_1, 1'b0);
      queue_item(8'hFF, 1'b0);

      queue_random(610);
      wait (pending_bytes.size() < 300);
      @(posedge clock);
      hold_sender <= 1'b1;
      repeat (2) @(posedge clock);
      wait (!req_valid && expected_headers.size() == 0);
      repeat (4) @(posedge clock);
      hold_sender <= 1'b0;
      wait (pending_bytes.size() == 0);

      @(posedge clock);
      send_idle_pct <= 70;
      recv_stall_pct <= 32;
      queue_random(610);
      wait (pending_bytes.size() == 0);

      @(posedge clock);
      send_idle_pct <= 0;
      recv_stall_pct <= 0;
      queue_random(610);
      wait (pending_bytes.size() == 0);
      @(posedge clock);
      wait (!req_valid);
      wait (expected_headers.size() == 0);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes and checked %0d results: %0d complete headers, %0d truncated.",
               bytes_accepted, results_seen, status_count[pnmhp_pkg::ST_OK],
               status_count[pnmhp_pkg::ST_TRUNC]);
      $display("Bad magic: %0d not P, %0d not P5/P6; %0d results carried the saturation flag.",
               status_count[pnmhp_pkg::ST_NOT_P], status_count[pnmhp_pkg::ST_NOT_RAW],
               overflow_count);
      if (mismatch_count == 0) begin
         $display("[pnm_header_parser_core] OK");
      end else begin
         $display("%0d mismatches.", mismatch_count);
         $display("[pnm_header_parser_core] ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/pnmhp_pkg.sv
hdl/pnmhp_step.sv
hdl/pnm_header_parser_core.sv
sim/pnm_header_parser_core_tb.sv
